// ===== hw/rtl/ple_pkg.sv =====
// Shared types and codes for the positional list engine.
// No dependencies; imported by ple_seq, positional_list_engine_top, ple_list_checker and the testbench.
package ple_pkg;

  // Request opcodes
  localparam logic [2:0] OP_ADD_FRONT = 3'd0;
  localparam logic [2:0] OP_ADD_REAR  = 3'd1;
  localparam logic [2:0] OP_REM_FRONT = 3'd2;
  localparam logic [2:0] OP_REM_REAR  = 3'd3;
  localparam logic [2:0] OP_INSERT_AT = 3'd4;
  localparam logic [2:0] OP_REMOVE_AT = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // Kind of store walk handed to the sequencer
  typedef logic [1:0] kind_t;
  localparam kind_t K_NONE = 2'd0;
  localparam kind_t K_PUT  = 2'd1;
  localparam kind_t K_TAKE = 2'd2;

  typedef struct packed {
    logic  go;
    kind_t kind;
  } ple_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ple_seq_st_t;

endpackage

// ===== hw/rtl/positional_list_engine_top.sv =====
// Positional list engine top level: request check, element count, result
// register. Depends on ple_pkg, ple_store and ple_seq.
//
// A request is taken at a clock edge where start is high and busy is low.
// Requests that fail their check (underflow, bad position, full list) and
// unused opcodes change nothing: their result appears on the next cycle and
// busy never rises. Accepted adds, inserts and removals walk the element
// store through one write port and one registered read port, moving one
// entry per cycle over the entries from the target position to the tail;
// busy stays high while the walk runs. An add or insert with nothing to
// shift (add at the rear, insert at count+1, add to an empty list) skips
// the walk and only writes the new element. Each result is shown for
// exactly one cycle with done high and must be captured then: there is no
// way to hold it off. removed_value is zero for anything but a successful
// removal, and count_after is the element count after the request.
module positional_list_engine_top #(
  parameter int CAPACITY   = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [6:0]  position,
  input  logic [31:0] value,
  output logic        done,
  output logic [31:0] removed_value,
  output logic [1:0]  status,
  output logic [6:0]  count_after
);
  import ple_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > 7) ? CW : 7) + 1;

  logic [CW-1:0]         count;
  kind_t                 kind;
  logic                  acc;
  logic [PW-1:0]         cnt_w;
  logic [PW-1:0]         pos_w;
  logic [PW-1:0]         pos_m1;
  logic [PW-1:0]         cnt_m1;
  logic                  full;
  logic                  empty;
  kind_t                 chk_kind;
  logic [1:0]            chk_status;
  logic [AW-1:0]         chk_idx;
  logic [AW-1:0]         chk_lim;
  logic [63:0]           val_wide;
  logic [ELEM_WIDTH-1:0] val_e;
  logic [PW-1:0]         cnt_after_w;
  logic [CW-1:0]         count_next;
  logic [63:0]           rem_wide;
  ple_req_t              req;
  ple_seq_st_t           seq_st;
  logic [ELEM_WIDTH-1:0] seq_removed;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [ELEM_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [ELEM_WIDTH-1:0] mem_rdata;

  // Hold off new transfers while a walk runs or its result is being posted
  assign busy = seq_st.busy || seq_st.done;
  assign acc  = start && !busy;

  assign cnt_w  = PW'(count);
  assign pos_w  = PW'(position);
  assign pos_m1 = pos_w - PW'(1);
  assign cnt_m1 = cnt_w - PW'(1);
  assign full   = (cnt_w == PW'(CAPACITY));
  assign empty  = (count == '0);

  // Keep the element in its low ELEM_WIDTH bits
  assign val_wide = {32'd0, value};
  assign val_e    = val_wide[ELEM_WIDTH-1:0];

  // Check the request against the current count and pick the walk to run
  always_comb begin
    chk_kind   = K_NONE;
    chk_status = ST_OK;
    chk_idx    = '0;
    chk_lim    = '0;
    unique case (opcode)
      OP_ADD_FRONT: begin
        if (full) begin
          chk_status = ST_FULL;
        end else begin
          chk_kind = K_PUT;
          chk_lim  = cnt_w[AW-1:0];
        end
      end
      OP_ADD_REAR: begin
        if (full) begin
          chk_status = ST_FULL;
        end else begin
          chk_kind = K_PUT;
          chk_idx  = cnt_w[AW-1:0];
          chk_lim  = cnt_w[AW-1:0];
        end
      end
      OP_REM_FRONT: begin
        if (empty) begin
          chk_status = ST_UNDER;
        end else begin
          chk_kind = K_TAKE;
          chk_lim  = cnt_m1[AW-1:0];
        end
      end
      OP_REM_REAR: begin
        if (empty) begin
          chk_status = ST_UNDER;
        end else begin
          chk_kind = K_TAKE;
          chk_idx  = cnt_m1[AW-1:0];
          chk_lim  = cnt_m1[AW-1:0];
        end
      end
      OP_INSERT_AT: begin
        if (pos_w == '0 || pos_w > cnt_w + PW'(1)) begin
          chk_status = ST_RANGE;
        end else if (full) begin
          chk_status = ST_FULL;
        end else begin
          chk_kind = K_PUT;
          chk_idx  = pos_m1[AW-1:0];
          chk_lim  = cnt_w[AW-1:0];
        end
      end
      OP_REMOVE_AT: begin
        if (pos_w == '0 || pos_w > cnt_w) begin
          chk_status = ST_RANGE;
        end else begin
          chk_kind = K_TAKE;
          chk_idx  = pos_m1[AW-1:0];
          chk_lim  = cnt_m1[AW-1:0];
        end
      end
      default: begin
        chk_kind = K_NONE;
      end
    endcase
  end

  assign req.go   = acc && (chk_kind != K_NONE);
  assign req.kind = chk_kind;

  // Count after the walk that is finishing
  assign count_next  = (kind == K_PUT) ? count + CW'(1) : count - CW'(1);
  assign cnt_after_w = PW'(count_next);

  always_comb begin
    rem_wide                 = '0;
    rem_wide[ELEM_WIDTH-1:0] = seq_removed;
  end

  ple_store #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .EW    (ELEM_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ple_seq #(
    .AW (AW),
    .EW (ELEM_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .idx       (chk_idx),
    .lim       (chk_lim),
    .value     (val_e),
    .st        (seq_st),
    .removed   (seq_removed),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      kind  <= K_NONE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (seq_st.done) begin
        // Post the walk's result and commit the new count
        count         <= count_next;
        done          <= 1'b1;
        status        <= ST_OK;
        count_after   <= cnt_after_w[6:0];
        removed_value <= (kind == K_TAKE) ? rem_wide[31:0] : 32'd0;
      end else if (acc) begin
        kind <= chk_kind;
        if (chk_kind == K_NONE) begin
          // Failed check or unused opcode: answer at once, list unchanged
          done          <= 1'b1;
          status        <= chk_status;
          count_after   <= cnt_w[6:0];
          removed_value <= 32'd0;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_w <= PW'(CAPACITY))
    else $error("element count above capacity");

  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    req.go |=> busy)
    else $error("walk launched but busy did not rise");

  a_walk_result: assert property (@(posedge clk) disable iff (rst)
    seq_st.done |=> done && status == ST_OK)
    else $error("finished walk did not post an ok result");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> removed_value == 32'd0)
    else $error("failed request returned a nonzero element");
`endif

endmodule

// ===== hw/rtl/ple_store.sv =====
// Element store: single write port, single registered read port.
// No package dependencies; instantiated by positional_list_engine_top.
module ple_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int EW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [EW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [EW-1:0] rdata
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/ple_seq.sv =====
// Shift sequencer: walks the element store one entry per cycle with a shared
// address stepper. Depends on ple_pkg; drives the ports of ple_store.
module ple_seq #(
  parameter int AW = 6,
  parameter int EW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ple_pkg::ple_req_t    req,
  input  logic [AW-1:0]        idx,
  input  logic [AW-1:0]        lim,
  input  logic [EW-1:0]        value,
  output ple_pkg::ple_seq_st_t st,
  output logic [EW-1:0]        removed,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [EW-1:0]        mem_wdata,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr,
  input  logic [EW-1:0]        mem_rdata
);
  import ple_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FILL  = 2'd3;

  logic [1:0]    state;
  logic          up;
  logic          first;
  logic          rd_pend;
  logic          done;
  logic [AW-1:0] ptr;
  logic [AW-1:0] wrp;
  logic [AW-1:0] stop;
  logic [AW-1:0] fill_idx;
  logic [EW-1:0] fill_val;
  logic [AW-1:0] step;
  logic [AW-1:0] ptr_next;
  logic [AW-1:0] wrp_next;

  // Read and write pointers advance in the same direction
  assign step     = up ? '1 : AW'(1);
  assign ptr_next = ptr + step;
  assign wrp_next = wrp + step;

  assign mem_re    = (state == S_WALK);
  assign mem_raddr = ptr;
  assign mem_we    = (rd_pend && !first) || (state == S_FILL);
  assign mem_waddr = (state == S_FILL) ? fill_idx : wrp;
  assign mem_wdata = (state == S_FILL) ? fill_val : mem_rdata;

  assign st.busy = (state != S_IDLE);
  assign st.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
      first   <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      // First data of a removal is the removed element; all later data moves
      if (rd_pend) begin
        if (first) begin
          removed <= mem_rdata;
          first   <= 1'b0;
        end else begin
          wrp <= wrp_next;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (req.go) begin
            fill_idx <= idx;
            fill_val <= value;
            if (req.kind == K_PUT) begin
              up    <= 1'b1;
              first <= 1'b0;
              stop  <= idx;
              ptr   <= lim - AW'(1);
              wrp   <= lim;
              state <= (idx == lim) ? S_FILL : S_WALK;
            end else begin
              up    <= 1'b0;
              first <= 1'b1;
              stop  <= lim;
              ptr   <= idx;
              wrp   <= idx;
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          rd_pend <= 1'b1;
          if (ptr == stop) begin
            state <= S_DRAIN;
          end else begin
            ptr <= ptr_next;
          end
        end
        S_DRAIN: begin
          rd_pend <= 1'b0;
          if (up) begin
            state <= S_FILL;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_FILL: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sim/ple_list_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the positional list engine: mirrors the list, predicts the
// result of each accepted request and checks it against the done strobe.
// Depends on ple_pkg; instantiated beside the DUT by positional_list_engine_top_tb.
module ple_list_checker
  import ple_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  opcode,
  input  logic [6:0]  position,
  input  logic [31:0] value,
  input  logic        done,
  input  logic [31:0] removed_value,
  input  logic [1:0]  status,
  input  logic [6:0]  count_after,
  output int          fail_count,
  output int          pending,
  output int          list_size
);

  typedef struct packed {
    logic [31:0] removed;
    logic [1:0]  stat;
    logic [6:0]  count;
  } list_result_t;

  logic [31:0]  elems [CAPACITY];
  list_result_t due_results [$];
  list_result_t want;

  // Apply one request to the mirrored list and return what the block must report.
  task automatic apply_request(input logic [2:0] op, input logic [6:0] pos,
                               input logic [31:0] val, output list_result_t res);
    int idx;
    int k;
    bit put;
    bit take;
    res  = '0;
    idx  = 0;
    put  = 1'b0;
    take = 1'b0;
    case (op)
      OP_ADD_FRONT: begin
        put = 1'b1;
        idx = 0;
      end
      OP_ADD_REAR: begin
        put = 1'b1;
        idx = list_size;
      end
      OP_REM_FRONT: begin
        if (list_size == 0) res.stat = ST_UNDER;
        else begin
          take = 1'b1;
          idx  = 0;
        end
      end
      OP_REM_REAR: begin
        if (list_size == 0) res.stat = ST_UNDER;
        else begin
          take = 1'b1;
          idx  = list_size - 1;
        end
      end
      OP_INSERT_AT: begin
        // position check ranks ahead of the full check
        if (pos < 1 || pos > list_size + 1) res.stat = ST_RANGE;
        else begin
          put = 1'b1;
          idx = pos - 1;
        end
      end
      OP_REMOVE_AT: begin
        if (pos < 1 || pos > list_size) res.stat = ST_RANGE;
        else begin
          take = 1'b1;
          idx  = pos - 1;
        end
      end
      default: ;
    endcase
    if (put && list_size >= CAPACITY) begin
      res.stat = ST_FULL;
      put      = 1'b0;
    end
    if (put) begin
      for (k = list_size; k > idx; k--) elems[k] = elems[k-1];
      elems[idx] = val;
      list_size++;
    end
    if (take) begin
      res.removed = elems[idx];
      for (k = idx; k < list_size - 1; k++) elems[k] = elems[k+1];
      list_size--;
    end
    res.count = list_size[6:0];
  endtask

  always @(posedge clk) begin
    if (rst) begin
      list_size  = 0;
      fail_count = 0;
      due_results.delete();
    end else begin
      if (start && !busy) begin
        apply_request(opcode, position, value, want);
        due_results.push_back(want);
      end
      if (done) begin
        if (due_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected: removed %h status %0d count %0d",
                   $time, removed_value, status, count_after);
        end else begin
          want = due_results.pop_front();
          if (removed_value !== want.removed) begin
            fail_count++;
            $display("%0t: removed_value expected %h actual %h",
                     $time, want.removed, removed_value);
          end
          if (status !== want.stat) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d", $time, want.stat, status);
          end
          if (count_after !== want.count) begin
            fail_count++;
            $display("%0t: count_after expected %0d actual %0d",
                     $time, want.count, count_after);
          end
        end
      end
    end
    pending = due_results.size();
  end

endmodule

// ===== sim/positional_list_engine_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the positional list engine: clock, reset, request
// stimulus and verdict. Depends on ple_pkg, the DUT and ple_list_checker.
module positional_list_engine_top_tb;
  import ple_pkg::*;

  localparam int CAPACITY  = 64;
  localparam int PHASE_LEN = 306;     // random transfers per idling phase
  localparam int LINGER    = 12;      // requests spent at a full or empty list
  // Slowest correct run is roughly 1250 walks plus sender gaps; the watchdog
  // limit allows several times its length.
  localparam int CYCLE_LIMIT = 1_000_000;

  // opcodes the block leaves unused
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        start    = 1'b0;
  logic [2:0]  opcode   = OP_ADD_FRONT;
  logic [6:0]  position = '0;
  logic [31:0] value    = '0;
  logic        busy;
  logic        done;
  logic [31:0] removed_value;
  logic [1:0]  status;
  logic [6:0]  count_after;

  int fail_count;
  int pending;
  int list_size;
  int cycle_count = 0;

  positional_list_engine_top #(
    .CAPACITY  (CAPACITY),
    .ELEM_WIDTH(32)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .position     (position),
    .value        (value),
    .done         (done),
    .removed_value(removed_value),
    .status       (status),
    .count_after  (count_after)
  );

  ple_list_checker #(
    .CAPACITY(CAPACITY)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .position     (position),
    .value        (value),
    .done         (done),
    .removed_value(removed_value),
    .status       (status),
    .count_after  (count_after),
    .fail_count   (fail_count),
    .pending      (pending),
    .list_size    (list_size)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("positional_list_engine_top_tb NOT OK");
      $finish;
    end
  end

  // All driving tasks start and end on a falling edge. busy only moves on a
  // rising edge, so its value here is what the next rising edge sees: once it
  // is low with start high, that edge completes the transfer.
  task automatic issue(input logic [2:0] op, input logic [6:0] pos, input logic [31:0] val);
    start    <= 1'b1;
    opcode   <= op;
    position <= pos;
    value    <= val;
    // hold the request until the engine is free
    while (busy) @(negedge clk);
    // advance past the transfer edge
    @(negedge clk);
  endtask

  // Drop start for a random run of cycles; pct is the chance per cycle.
  task automatic pause_sender(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  // One random request. filling biases toward adds so the list reaches full,
  // otherwise toward removals so it drains to empty. Fields are picked after
  // the gap, so list_size is the count the request will meet.
  task automatic random_request(input bit filling, input int pct);
    int          pick;
    logic [2:0]  op;
    logic [6:0]  pos;
    logic [31:0] val;
    pause_sender(pct);
    pick = $urandom_range(99);
    if (pick < 3) op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
    else if ($urandom_range(99) < (filling ? 80 : 20)) begin
      case ($urandom_range(2))
        0:       op = OP_ADD_FRONT;
        1:       op = OP_ADD_REAR;
        default: op = OP_INSERT_AT;
      endcase
    end else begin
      case ($urandom_range(2))
        0:       op = OP_REM_FRONT;
        1:       op = OP_REM_REAR;
        default: op = OP_REMOVE_AT;
      endcase
    end
    // positions mostly land on or just past the list; some are pure noise
    pick = $urandom_range(99);
    if (pick < 75)      pos = 7'($urandom_range(list_size + 2, 0));
    else if (pick < 82) pos = 7'(list_size);
    else if (pick < 89) pos = 7'(list_size + 1);
    else                pos = 7'($urandom());
    pick = $urandom_range(99);
    if (pick < 5)       val = '0;
    else if (pick < 10) val = '1;
    else                val = $urandom();
    issue(op, pos, val);
  endtask

  int idle_pct [4] = '{0, 82, 0, 18};
  bit filling;
  int linger;

  initial begin
    // hold reset, release on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: removals from an empty list, bad positions on both sides,
    // end-of-list inserts, extreme values and the unused opcodes.
    issue(OP_REM_FRONT, 7'd0,   32'h1234_5678);  // empty: underflow
    issue(OP_REM_REAR,  7'd0,   32'h0);          // empty: underflow
    issue(OP_REMOVE_AT, 7'd1,   32'h0);          // empty: range, not underflow
    issue(OP_REMOVE_AT, 7'd0,   32'h0);
    issue(OP_INSERT_AT, 7'd0,   32'hDEAD_BEEF);  // position zero
    issue(OP_INSERT_AT, 7'd2,   32'hDEAD_BEEF);  // past count+1
    issue(OP_INSERT_AT, 7'd1,   32'hFFFF_FFFF);  // into empty list
    issue(OP_ADD_FRONT, 7'd127, 32'h0000_0000);
    issue(OP_ADD_REAR,  7'd0,   32'hA5A5_A5A5);
    issue(OP_INSERT_AT, 7'd4,   32'h8000_0001);  // at count+1: new tail
    issue(OP_INSERT_AT, 7'd2,   32'h0000_0001);  // middle shift
    issue(OP_INSERT_AT, 7'd7,   32'h7FFF_FFFE);  // count+2: range
    issue(OP_REMOVE_AT, 7'd6,   32'h0);          // count+1: range
    issue(OP_REMOVE_AT, 7'd5,   32'hFFFF_FFFF);  // tail
    issue(OP_REMOVE_AT, 7'd2,   32'h0);          // middle
    issue(OP_SPARE_LO,  7'd3,   32'h5555_5555);  // ignored
    issue(OP_SPARE_HI,  7'd127, 32'hFFFF_FFFF);  // ignored
    issue(OP_REMOVE_AT, 7'd127, 32'h0);
    issue(OP_INSERT_AT, 7'd127, 32'h0);
    issue(OP_REM_FRONT, 7'd0,   32'h0);
    issue(OP_REM_REAR,  7'd0,   32'h0);
    issue(OP_REMOVE_AT, 7'd1,   32'h0);          // last element
    issue(OP_ADD_REAR,  7'd1,   32'h5A5A_5A5A);

    // Random: swing the list between full and empty, staying a few requests
    // at each extreme so full and underflow cases get hit repeatedly.
    filling = 1'b1;
    linger  = 0;
    foreach (idle_pct[ph]) begin
      for (int i = 0; i < PHASE_LEN; i++) begin
        random_request(filling, idle_pct[ph]);
        if (filling ? (list_size == CAPACITY) : (list_size == 0)) linger++;
        if (linger > LINGER) begin
          filling = !filling;
          linger  = 0;
        end
      end
    end

    // Drain: drop start, wait for every result, then for a full walk more.
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (CAPACITY + 8) @(negedge clk);

    if (fail_count == 0) begin
      $display("positional_list_engine_top_tb OK");
    end else begin
      $display("positional_list_engine_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ple_pkg.sv
hw/rtl/ple_store.sv
hw/rtl/ple_seq.sv
hw/rtl/positional_list_engine_top.sv
sim/ple_list_checker.sv
sim/positional_list_engine_top_tb.sv
